[sv/rrat_pkg.sv]
// Shared types and codes for the receive reorder/ack tracker.
`timescale 1ns / 1ps
`default_nettype none
package rrat_pkg;

    localparam int LEN_BITS = 16;

    localparam logic [1:0] FN_RECV     = 2'd0;
    localparam logic [1:0] FN_POP_ACK  = 2'd1;
    localparam logic [1:0] FN_POP_KEEP = 2'd2;
    localparam logic [1:0] FN_POP_HOLD = 2'd3;

    localparam logic [2:0] ST_DELIVERED = 3'd0;
    localparam logic [2:0] ST_DUPLICATE = 3'd1;
    localparam logic [2:0] ST_BUFFERED  = 3'd2;
    localparam logic [2:0] ST_STALE     = 3'd3;
    localparam logic [2:0] ST_ACK_FULL  = 3'd4;
    localparam logic [2:0] ST_HOLD_FULL = 3'd5;
    localparam logic [2:0] ST_EMPTY     = 3'd6;

    // per-cycle commands to one sorted store
    typedef struct packed {
        logic rd;
        logic wr;
        logic pop;
        logic push;
    } store_ctl_t;

    // flags from the shared subtract/compare unit (a - b)
    typedef struct packed {
        logic lt;
        logic eq;
        logic one;
        logic gt1;
    } cmp_t;

endpackage
`default_nettype wire

[sv/rrat_if.sv]
// Request and response channel interfaces.
`timescale 1ns / 1ps
`default_nettype none
interface rrat_req_if #(
    parameter int SEQ_BITS    = 24,
    parameter int HANDLE_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   func;
    logic [SEQ_BITS-1:0]          seq_in;
    logic                         reset_mark;
    logic [HANDLE_BITS-1:0]       payload_handle;
    logic [rrat_pkg::LEN_BITS-1:0] payload_length;

    modport source (output valid, func, seq_in, reset_mark, payload_handle, payload_length,
                    input ready);
    modport sink (input valid, func, seq_in, reset_mark, payload_handle, payload_length,
                  output ready);
endinterface

interface rrat_rsp_if #(
    parameter int SEQ_BITS    = 24,
    parameter int HANDLE_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic                         ok;
    logic [2:0]                   status;
    logic [SEQ_BITS-1:0]          seq_out;
    logic [HANDLE_BITS-1:0]       handle_out;
    logic [rrat_pkg::LEN_BITS-1:0] length_out;

    modport source (output valid, ok, status, seq_out, handle_out, length_out, input ready);
    modport sink (input valid, ok, status, seq_out, handle_out, length_out, output ready);
endinterface
`default_nettype wire

[sv/rrat_store.sv]
// Circular sorted store: one read and one write port, head pointer and fill count.
`timescale 1ns / 1ps
`default_nettype none
module rrat_store #(
    parameter int DEPTH = 32,
    parameter int W     = 24
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire rrat_pkg::store_ctl_t         ctl,
    input  wire logic [$clog2(DEPTH+1)-1:0]   rd_idx,
    input  wire logic [$clog2(DEPTH+1)-1:0]   wr_idx,
    input  wire logic [W-1:0]                 wr_data,
    output logic      [W-1:0]                 rd_data,
    output logic      [$clog2(DEPTH+1)-1:0]   count
);
    localparam int CW = $clog2(DEPTH+1);
    localparam int AW = $clog2(DEPTH);
    localparam logic [CW:0] DEPTH_W = (CW+1)'(DEPTH);

    logic [W-1:0]  mem [DEPTH];
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] rd_phys, wr_phys;

    function automatic logic [AW-1:0] wrap(input logic [CW:0] s);
        logic [CW:0] t;
        t = (s >= DEPTH_W) ? s - DEPTH_W : s;
        return t[AW-1:0];
    endfunction

    always_comb
    begin
        rd_phys    = wrap((CW+1)'(head_reg) + (CW+1)'(rd_idx));
        wr_phys    = wrap((CW+1)'(head_reg) + (CW+1)'(wr_idx));
        head_next  = ctl.pop ? wrap((CW+1)'(head_reg) + (CW+1)'(1)) : head_reg;
        count_next = count_reg;
        if (ctl.pop)
        begin
            count_next = count_reg - CW'(1);
        end
        else if (ctl.push)
        begin
            count_next = count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr)
        begin
            mem[wr_phys] <= wr_data;
        end
        if (ctl.rd)
        begin
            rd_data <= mem[rd_phys];
        end
    end

    assign count = count_reg;

endmodule
`default_nettype wire

[sv/rrat_cmp.sv]
// Shared sequence subtractor: ordering flags of a against b.
`timescale 1ns / 1ps
`default_nettype none
module rrat_cmp #(
    parameter int SEQ_BITS = 24
) (
    input  wire logic [SEQ_BITS-1:0] a,
    input  wire logic [SEQ_BITS-1:0] b,
    output rrat_pkg::cmp_t           flags
);
    logic [SEQ_BITS:0] diff;

    always_comb
    begin
        diff      = {1'b0, a} - {1'b0, b};
        flags.lt  = diff[SEQ_BITS];
        flags.eq  = (diff == '0);
        flags.one = (diff == (SEQ_BITS+1)'(1));
        flags.gt1 = !flags.lt && !flags.eq && !flags.one;
    end

endmodule
`default_nettype wire

[sv/receive_reorder_ack_tracker.sv]
// Top level: sequencer driving the ack store, reorder store and shared compare unit.
//
//   channel | dir | handshake     | payload
//   req     | in  | valid/ready   | func, seq_in, reset_mark, payload_handle, payload_length
//   rsp     | out | valid/ready   | ok, status, seq_out, handle_out, length_out
//
// One request at a time. Each stored entry visited costs a registered memory read,
// then a compare in the single subtractor; a sorted insert shifts one entry per
// read/write step. Pop ack is a read, then the response; pop buffered drops stale
// held entries (a read and a compare each) before it reads and checks the front;
// a receive scans and shifts the ack store, then may scan and shift the reorder store.
// Async active-low reset empties both stores. req.ready is low while busy or while
// the previous response waits on rsp.ready.
`timescale 1ns / 1ps
`default_nettype none
module receive_reorder_ack_tracker #(
    parameter int ACK_DEPTH   = 32,
    parameter int HOLD_DEPTH  = 32,
    parameter int SEQ_BITS    = 24,
    parameter int HANDLE_BITS = 16
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    rrat_req_if.sink    req,
    rrat_rsp_if.source  rsp
);
    localparam int LB   = rrat_pkg::LEN_BITS;
    localparam int ACW  = $clog2(ACK_DEPTH+1);
    localparam int HCW  = $clog2(HOLD_DEPTH+1);
    localparam int MAXD = (ACK_DEPTH > HOLD_DEPTH) ? ACK_DEPTH : HOLD_DEPTH;
    localparam int IW   = $clog2(MAXD+1);
    localparam int HW   = SEQ_BITS + HANDLE_BITS + LB;

    typedef enum logic [19:0] {
        S_IDLE       = 20'h00001,
        S_APURGE_RD  = 20'h00002,
        S_APURGE_CMP = 20'h00004,
        S_ASCAN_RD   = 20'h00008,
        S_ASCAN_CMP  = 20'h00010,
        S_APLACE     = 20'h00020,
        S_ASHIFT_RD  = 20'h00040,
        S_ASHIFT_WR  = 20'h00080,
        S_AINS       = 20'h00100,
        S_RXDEC      = 20'h00200,
        S_HPURGE_RD  = 20'h00400,
        S_HPURGE_CMP = 20'h00800,
        S_HSCAN_RD   = 20'h01000,
        S_HSCAN_CMP  = 20'h02000,
        S_HSHIFT_RD  = 20'h04000,
        S_HSHIFT_WR  = 20'h08000,
        S_HINS       = 20'h10000,
        S_PFRONT_RD  = 20'h20000,
        S_PFRONT_CMP = 20'h40000,
        S_PACK_CMP   = 20'h80000
    } state_t;

    state_t                 state_reg, state_next;
    logic [1:0]             func_reg, func_next;
    logic [SEQ_BITS-1:0]    seq_reg, seq_next;
    logic                   rst_reg, rst_next;
    logic [HANDLE_BITS-1:0] hnd_reg, hnd_next;
    logic [LB-1:0]          len_reg, len_next;
    logic [SEQ_BITS-1:0]    last_reg, last_next;
    logic                   known_reg, known_next;
    logic [IW-1:0]          idx_reg, idx_next;
    logic [IW-1:0]          pos_reg, pos_next;

    logic                   res_valid_reg, res_valid_next;
    logic                   res_ok_reg, res_ok_next;
    logic [2:0]             res_st_reg, res_st_next;
    logic [SEQ_BITS-1:0]    res_seq_reg, res_seq_next;
    logic [HANDLE_BITS-1:0] res_h_reg, res_h_next;
    logic [LB-1:0]          res_l_reg, res_l_next;

    rrat_pkg::store_ctl_t   a_ctl, h_ctl;
    logic [ACW-1:0]         a_rd_idx, a_wr_idx, a_count;
    logic [HCW-1:0]         h_rd_idx, h_wr_idx, h_count;
    logic [SEQ_BITS-1:0]    a_wr_data, a_rd;
    logic [HW-1:0]          h_wr_data, h_rd;
    logic [SEQ_BITS-1:0]    h_rd_seq;
    logic [HANDLE_BITS-1:0] h_rd_hnd;
    logic [LB-1:0]          h_rd_len;

    logic [SEQ_BITS-1:0]    cmp_a, cmp_b;
    rrat_pkg::cmp_t         cf;
    logic                   accept;
    logic [IW-1:0]          a_cnt_w, h_cnt_w;

    assign h_rd_seq = h_rd[HW-1 -: SEQ_BITS];
    assign h_rd_hnd = h_rd[LB +: HANDLE_BITS];
    assign h_rd_len = h_rd[LB-1:0];
    assign a_cnt_w  = IW'(a_count);
    assign h_cnt_w  = IW'(h_count);

    assign req.ready = (state_reg == S_IDLE) && !res_valid_reg;
    assign accept    = req.valid && req.ready;

    rrat_store #(.DEPTH(ACK_DEPTH), .W(SEQ_BITS)) u_ack (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (a_ctl),
        .rd_idx  (a_rd_idx),
        .wr_idx  (a_wr_idx),
        .wr_data (a_wr_data),
        .rd_data (a_rd),
        .count   (a_count)
    );

    rrat_store #(.DEPTH(HOLD_DEPTH), .W(HW)) u_hold (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (h_ctl),
        .rd_idx  (h_rd_idx),
        .wr_idx  (h_wr_idx),
        .wr_data (h_wr_data),
        .rd_data (h_rd),
        .count   (h_count)
    );

    // operand select for the single subtractor
    always_comb
    begin
        case (state_reg)
            S_APURGE_CMP, S_ASCAN_CMP: cmp_a = a_rd;
            S_HPURGE_CMP, S_HSCAN_CMP, S_PFRONT_CMP: cmp_a = h_rd_seq;
            default: cmp_a = seq_reg;
        endcase
        if (state_reg == S_RXDEC || state_reg == S_PFRONT_CMP ||
            (state_reg == S_HPURGE_CMP && func_reg == rrat_pkg::FN_POP_HOLD))
        begin
            cmp_b = last_reg;
        end
        else
        begin
            cmp_b = seq_reg;
        end
    end

    rrat_cmp #(.SEQ_BITS(SEQ_BITS)) u_cmp (
        .a     (cmp_a),
        .b     (cmp_b),
        .flags (cf)
    );

    always_comb
    begin
        state_next     = state_reg;
        func_next      = func_reg;
        seq_next       = seq_reg;
        rst_next       = rst_reg;
        hnd_next       = hnd_reg;
        len_next       = len_reg;
        last_next      = last_reg;
        known_next     = known_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        res_valid_next = res_valid_reg && !rsp.ready;
        res_ok_next    = res_ok_reg;
        res_st_next    = res_st_reg;
        res_seq_next   = res_seq_reg;
        res_h_next     = res_h_reg;
        res_l_next     = res_l_reg;
        a_ctl          = '0;
        h_ctl          = '0;
        a_rd_idx       = idx_reg[ACW-1:0];
        a_wr_idx       = idx_reg[ACW-1:0];
        a_wr_data      = a_rd;
        h_rd_idx       = idx_reg[HCW-1:0];
        h_wr_idx       = idx_reg[HCW-1:0];
        h_wr_data      = h_rd;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    func_next    = req.func;
                    seq_next     = req.seq_in;
                    rst_next     = req.reset_mark;
                    hnd_next     = req.payload_handle;
                    len_next     = req.payload_length;
                    idx_next     = '0;
                    res_ok_next  = 1'b0;
                    res_st_next  = rrat_pkg::ST_EMPTY;
                    res_seq_next = '0;
                    res_h_next   = '0;
                    res_l_next   = '0;
                    case (req.func)
                        rrat_pkg::FN_RECV:
                        begin
                            state_next = req.reset_mark ? S_APURGE_RD : S_ASCAN_RD;
                        end
                        rrat_pkg::FN_POP_HOLD:
                        begin
                            if (h_count == '0)
                            begin
                                res_valid_next = 1'b1;
                            end
                            else
                            begin
                                state_next = known_reg ? S_HPURGE_RD : S_PFRONT_RD;
                            end
                        end
                        default:
                        begin
                            if (a_count == '0)
                            begin
                                res_valid_next = 1'b1;
                            end
                            else
                            begin
                                a_ctl.rd   = 1'b1;
                                a_rd_idx   = '0;
                                state_next = S_PACK_CMP;
                            end
                        end
                    endcase
                end
            end

            S_PACK_CMP:
            begin
                a_ctl.pop      = (func_reg == rrat_pkg::FN_POP_ACK) ||
                                 (a_count >= ACW'(2));
                res_ok_next    = 1'b1;
                res_st_next    = rrat_pkg::ST_DELIVERED;
                res_seq_next   = a_rd;
                res_valid_next = 1'b1;
                state_next     = S_IDLE;
            end

            // reset frame: drop ack entries below the new sequence
            S_APURGE_RD:
            begin
                if (a_count == '0)
                begin
                    idx_next   = '0;
                    state_next = S_ASCAN_RD;
                end
                else
                begin
                    a_ctl.rd   = 1'b1;
                    a_rd_idx   = '0;
                    state_next = S_APURGE_CMP;
                end
            end

            S_APURGE_CMP:
            begin
                if (cf.lt)
                begin
                    a_ctl.pop  = 1'b1;
                    state_next = S_APURGE_RD;
                end
                else
                begin
                    idx_next   = '0;
                    state_next = S_ASCAN_RD;
                end
            end

            S_ASCAN_RD:
            begin
                if (idx_reg == a_cnt_w)
                begin
                    pos_next   = idx_reg;
                    state_next = S_APLACE;
                end
                else
                begin
                    a_ctl.rd   = 1'b1;
                    state_next = S_ASCAN_CMP;
                end
            end

            S_ASCAN_CMP:
            begin
                if (cf.eq)
                begin
                    res_st_next    = rrat_pkg::ST_DUPLICATE;
                    res_seq_next   = seq_reg;
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else if (!cf.lt)
                begin
                    pos_next   = idx_reg;
                    state_next = S_APLACE;
                end
                else
                begin
                    idx_next   = idx_reg + IW'(1);
                    state_next = S_ASCAN_RD;
                end
            end

            S_APLACE:
            begin
                if (a_count == ACW'(ACK_DEPTH))
                begin
                    res_st_next    = rrat_pkg::ST_ACK_FULL;
                    res_seq_next   = seq_reg;
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    idx_next   = a_cnt_w;
                    state_next = S_ASHIFT_RD;
                end
            end

            // move entries up by one, from the tail down to the insert point
            S_ASHIFT_RD:
            begin
                if (idx_reg == pos_reg)
                begin
                    state_next = S_AINS;
                end
                else
                begin
                    a_ctl.rd   = 1'b1;
                    a_rd_idx   = ACW'(idx_reg - IW'(1));
                    state_next = S_ASHIFT_WR;
                end
            end

            S_ASHIFT_WR:
            begin
                a_ctl.wr   = 1'b1;
                idx_next   = idx_reg - IW'(1);
                state_next = S_ASHIFT_RD;
            end

            S_AINS:
            begin
                a_ctl.wr   = 1'b1;
                a_ctl.push = 1'b1;
                a_wr_idx   = pos_reg[ACW-1:0];
                a_wr_data  = seq_reg;
                state_next = S_RXDEC;
            end

            S_RXDEC:
            begin
                res_seq_next = seq_reg;
                if (rst_reg)
                begin
                    state_next = S_HPURGE_RD;
                end
                else if (!known_reg || cf.one)
                begin
                    last_next      = seq_reg;
                    known_next     = 1'b1;
                    res_ok_next    = 1'b1;
                    res_st_next    = rrat_pkg::ST_DELIVERED;
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else if (cf.gt1)
                begin
                    if (h_count == HCW'(HOLD_DEPTH))
                    begin
                        res_st_next    = rrat_pkg::ST_HOLD_FULL;
                        res_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = '0;
                        state_next = S_HSCAN_RD;
                    end
                end
                else
                begin
                    res_st_next    = rrat_pkg::ST_STALE;
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            // drop held entries at or below the key (new seq on reset, else last)
            S_HPURGE_RD:
            begin
                if (h_count == '0)
                begin
                    if (func_reg == rrat_pkg::FN_RECV)
                    begin
                        last_next      = seq_reg;
                        known_next     = 1'b1;
                        res_ok_next    = 1'b1;
                        res_st_next    = rrat_pkg::ST_DELIVERED;
                        res_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_PFRONT_RD;
                    end
                end
                else
                begin
                    h_ctl.rd   = 1'b1;
                    h_rd_idx   = '0;
                    state_next = S_HPURGE_CMP;
                end
            end

            S_HPURGE_CMP:
            begin
                if (cf.lt || cf.eq)
                begin
                    h_ctl.pop  = 1'b1;
                    state_next = S_HPURGE_RD;
                end
                else if (func_reg == rrat_pkg::FN_RECV)
                begin
                    last_next      = seq_reg;
                    known_next     = 1'b1;
                    res_ok_next    = 1'b1;
                    res_st_next    = rrat_pkg::ST_DELIVERED;
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    state_next = S_PFRONT_RD;
                end
            end

            S_HSCAN_RD:
            begin
                if (idx_reg == h_cnt_w)
                begin
                    pos_next   = idx_reg;
                    idx_next   = h_cnt_w;
                    state_next = S_HSHIFT_RD;
                end
                else
                begin
                    h_ctl.rd   = 1'b1;
                    state_next = S_HSCAN_CMP;
                end
            end

            S_HSCAN_CMP:
            begin
                if (!cf.lt && !cf.eq)
                begin
                    pos_next   = idx_reg;
                    idx_next   = h_cnt_w;
                    state_next = S_HSHIFT_RD;
                end
                else
                begin
                    idx_next   = idx_reg + IW'(1);
                    state_next = S_HSCAN_RD;
                end
            end

            S_HSHIFT_RD:
            begin
                if (idx_reg == pos_reg)
                begin
                    state_next = S_HINS;
                end
                else
                begin
                    h_ctl.rd   = 1'b1;
                    h_rd_idx   = HCW'(idx_reg - IW'(1));
                    state_next = S_HSHIFT_WR;
                end
            end

            S_HSHIFT_WR:
            begin
                h_ctl.wr   = 1'b1;
                idx_next   = idx_reg - IW'(1);
                state_next = S_HSHIFT_RD;
            end

            S_HINS:
            begin
                h_ctl.wr       = 1'b1;
                h_ctl.push     = 1'b1;
                h_wr_idx       = pos_reg[HCW-1:0];
                h_wr_data      = {seq_reg, hnd_reg, len_reg};
                res_st_next    = rrat_pkg::ST_BUFFERED;
                res_seq_next   = seq_reg;
                res_valid_next = 1'b1;
                state_next     = S_IDLE;
            end

            S_PFRONT_RD:
            begin
                if (h_count == '0)
                begin
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    h_ctl.rd   = 1'b1;
                    h_rd_idx   = '0;
                    state_next = S_PFRONT_CMP;
                end
            end

            S_PFRONT_CMP:
            begin
                if (cf.gt1)
                begin
                    res_st_next = rrat_pkg::ST_BUFFERED;
                end
                else
                begin
                    h_ctl.pop    = 1'b1;
                    last_next    = h_rd_seq;
                    known_next   = 1'b1;
                    res_ok_next  = 1'b1;
                    res_st_next  = rrat_pkg::ST_DELIVERED;
                    res_seq_next = h_rd_seq;
                    res_h_next   = h_rd_hnd;
                    res_l_next   = h_rd_len;
                end
                res_valid_next = 1'b1;
                state_next     = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            last_reg      <= '0;
            known_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            last_reg      <= last_next;
            known_reg     <= known_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg    <= func_next;
        seq_reg     <= seq_next;
        rst_reg     <= rst_next;
        hnd_reg     <= hnd_next;
        len_reg     <= len_next;
        idx_reg     <= idx_next;
        pos_reg     <= pos_next;
        res_ok_reg  <= res_ok_next;
        res_st_reg  <= res_st_next;
        res_seq_reg <= res_seq_next;
        res_h_reg   <= res_h_next;
        res_l_reg   <= res_l_next;
    end

    assign rsp.valid      = res_valid_reg;
    assign rsp.ok         = res_ok_reg;
    assign rsp.status     = res_st_reg;
    assign rsp.seq_out    = res_seq_reg;
    assign rsp.handle_out = res_h_reg;
    assign rsp.length_out = res_l_reg;

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    a_ack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        a_count <= ACW'(ACK_DEPTH))
        else $error("ack count beyond depth");

    a_hold_bound: assert property (@(posedge clk) disable iff (!rst_n)
        h_count <= HCW'(HOLD_DEPTH))
        else $error("reorder count beyond depth");

    a_ok_delivered: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.ok |-> rsp.status == rrat_pkg::ST_DELIVERED)
        else $error("ok set on a non-delivered response");

    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != S_IDLE || res_valid_reg)
        else $error("request accepted without work or response");

endmodule
`default_nettype wire

[tb/tb_receive_reorder_ack_tracker.sv]
// Testbench for the receive reorder/ack tracker: self-checking, random flow control.
`timescale 1ns / 1ps
`default_nettype none
module tb_receive_reorder_ack_tracker;

    localparam int ACKD  = 32;
    localparam int HOLDD = 32;
    localparam int SEQW  = 24;
    localparam int HW    = 16;
    localparam logic [SEQW-1:0] SEQ_MAX = 24'hFFFFFF;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct packed {
        logic            ok;
        logic [2:0]      status;
        logic [SEQW-1:0] seq;
        logic [HW-1:0]   handle;
        logic [15:0]     length;
    } result_t;

    logic clk;
    logic rst_n;

    rrat_req_if #(.SEQ_BITS(SEQW), .HANDLE_BITS(HW)) req ();
    rrat_rsp_if #(.SEQ_BITS(SEQW), .HANDLE_BITS(HW)) rsp ();

    receive_reorder_ack_tracker #(
        .ACK_DEPTH(ACKD), .HOLD_DEPTH(HOLDD), .SEQ_BITS(SEQW), .HANDLE_BITS(HW)
    ) DUT (
        .clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp)
    );

    // tracker state mirror
    logic [SEQW-1:0] acks[$];
    logic [SEQW-1:0] held_seq[$];
    logic [HW-1:0]   held_handle[$];
    logic [15:0]     held_length[$];
    logic [SEQW-1:0] last_delivered;
    logic            seen_any;

    result_t pending_results[$];
    int  mismatches;
    int  results_seen;
    int  requests_sent;
    int  delivered_cnt;
    int  buffered_cnt;
    int  full_cnt;
    int  cycles;
    bit  long_hold;
    bit  gaps_on;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic result_t mk(logic ok, logic [2:0] st, logic [SEQW-1:0] s,
                                   logic [HW-1:0] h, logic [15:0] l);
        result_t r;
        r.ok = ok; r.status = st; r.seq = s; r.handle = h; r.length = l;
        return r;
    endfunction

    function automatic void drop_held_head();
        held_seq.delete(0);
        held_handle.delete(0);
        held_length.delete(0);
    endfunction

    function automatic result_t track_request(logic [1:0] fn, logic [SEQW-1:0] s,
                                              logic rm, logic [HW-1:0] h, logic [15:0] l);
        int pos;
        logic [SEQW-1:0] front;
        logic [HW-1:0]   front_h;
        logic [15:0]     front_l;
        if (fn == rrat_pkg::FN_RECV)
        begin
            if (rm)
                while (acks.size() > 0 && acks[0] < s) acks.delete(0);
            pos = acks.size();
            for (int i = 0; i < acks.size(); i++)
            begin
                if (acks[i] == s) return mk(1'b0, rrat_pkg::ST_DUPLICATE, s, '0, '0);
                if (acks[i] > s)
                begin
                    pos = i;
                    break;
                end
            end
            if (acks.size() >= ACKD) return mk(1'b0, rrat_pkg::ST_ACK_FULL, s, '0, '0);
            acks.insert(pos, s);
            if (rm)
            begin
                while (held_seq.size() > 0 && held_seq[0] <= s) drop_held_head();
                last_delivered = s;
                seen_any = 1'b1;
                return mk(1'b1, rrat_pkg::ST_DELIVERED, s, '0, '0);
            end
            if (!seen_any)
            begin
                last_delivered = s;
                seen_any = 1'b1;
                return mk(1'b1, rrat_pkg::ST_DELIVERED, s, '0, '0);
            end
            if ({1'b0, s} > {1'b0, last_delivered} + 25'd1)
            begin
                if (held_seq.size() >= HOLDD)
                    return mk(1'b0, rrat_pkg::ST_HOLD_FULL, s, '0, '0);
                pos = held_seq.size();
                for (int i = 0; i < held_seq.size(); i++)
                    if (held_seq[i] > s)
                    begin
                        pos = i;
                        break;
                    end
                held_seq.insert(pos, s);
                held_handle.insert(pos, h);
                held_length.insert(pos, l);
                return mk(1'b0, rrat_pkg::ST_BUFFERED, s, '0, '0);
            end
            if ({1'b0, s} == {1'b0, last_delivered} + 25'd1)
            begin
                last_delivered = s;
                return mk(1'b1, rrat_pkg::ST_DELIVERED, s, '0, '0);
            end
            return mk(1'b0, rrat_pkg::ST_STALE, s, '0, '0);
        end
        if (fn == rrat_pkg::FN_POP_HOLD)
        begin
            if (held_seq.size() == 0) return mk(1'b0, rrat_pkg::ST_EMPTY, '0, '0, '0);
            if (seen_any)
                while (held_seq.size() > 0 && held_seq[0] <= last_delivered)
                    drop_held_head();
            if (held_seq.size() == 0) return mk(1'b0, rrat_pkg::ST_EMPTY, '0, '0, '0);
            if ({1'b0, held_seq[0]} > {1'b0, last_delivered} + 25'd1)
                return mk(1'b0, rrat_pkg::ST_BUFFERED, '0, '0, '0);
            front   = held_seq[0];
            front_h = held_handle[0];
            front_l = held_length[0];
            drop_held_head();
            last_delivered = front;
            seen_any = 1'b1;
            return mk(1'b1, rrat_pkg::ST_DELIVERED, front, front_h, front_l);
        end
        if (acks.size() == 0) return mk(1'b0, rrat_pkg::ST_EMPTY, '0, '0, '0);
        front = acks[0];
        if (fn == rrat_pkg::FN_POP_ACK || acks.size() >= 2) acks.delete(0);
        return mk(1'b1, rrat_pkg::ST_DELIVERED, front, '0, '0);
    endfunction

    // one request, with burst/gap pacing; called and returns at a falling edge
    task automatic send_request(logic [1:0] fn, logic [SEQW-1:0] s, logic rm = 1'b0,
                                logic [HW-1:0] h = '0, logic [15:0] l = '0);
        int gap;
        gap = 0;
        if (gaps_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 12);
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.valid          <= 1'b1;
        req.func           <= fn;
        req.seq_in         <= s;
        req.reset_mark     <= rm;
        req.payload_handle <= h;
        req.payload_length <= l;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
        pending_results.push_back(track_request(fn, s, rm, h, l));
        requests_sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        while (pending_results.size() > 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    function automatic logic [SEQW-1:0] rseq();
        return SEQW'($urandom());
    endfunction

    task automatic test_directed();
        send_request(rrat_pkg::FN_POP_ACK, '0);
        send_request(rrat_pkg::FN_POP_KEEP, '0);
        send_request(rrat_pkg::FN_POP_HOLD, '0);
        send_request(rrat_pkg::FN_RECV, 24'd100, 1'b0, 16'hFFFF, 16'hFFFF); // first packet
        send_request(rrat_pkg::FN_RECV, 24'd100);                           // duplicate
        send_request(rrat_pkg::FN_RECV, 24'd101, 1'b0, 16'h0001, 16'h0002); // in order
        send_request(rrat_pkg::FN_RECV, 24'd104, 1'b0, 16'hAAAA, 16'h5555); // gap
        send_request(rrat_pkg::FN_RECV, 24'd103, 1'b0, 16'h5555, 16'hAAAA);
        send_request(rrat_pkg::FN_RECV, 24'd50);                            // stale
        send_request(rrat_pkg::FN_POP_HOLD, '0);                            // gap before front
        send_request(rrat_pkg::FN_RECV, 24'd102);
        send_request(rrat_pkg::FN_POP_HOLD, '0);
        send_request(rrat_pkg::FN_POP_HOLD, '0);
        send_request(rrat_pkg::FN_RECV, 24'd110, 1'b0, 16'h1234, 16'h4321);
        send_request(rrat_pkg::FN_RECV, 24'd90, 1'b1);                      // reset frame, low
        send_request(rrat_pkg::FN_RECV, SEQ_MAX, 1'b1, 16'hFFFF, 16'hFFFF); // reset purges all
        send_request(rrat_pkg::FN_POP_HOLD, '0);
        send_request(rrat_pkg::FN_POP_KEEP, '0);
        send_request(rrat_pkg::FN_POP_KEEP, '0);
        send_request(rrat_pkg::FN_POP_ACK, '0);
        send_request(rrat_pkg::FN_POP_KEEP, '0);                            // ack store now empty
        send_request(rrat_pkg::FN_RECV, 24'd0, 1'b1);
        send_request(rrat_pkg::FN_POP_ACK, '0);
        send_request(rrat_pkg::FN_POP_ACK, '0);
        drain();
    endtask

    // fill the reorder store to overflow, then the ack queue
    task automatic test_full();
        logic [SEQW-1:0] base;
        base = 24'h800000;
        send_request(rrat_pkg::FN_RECV, base, 1'b1);
        for (int i = 0; i < 36; i++)
        begin
            send_request(rrat_pkg::FN_RECV, base + 24'd2 + 24'(i) * 24'd3, 1'b0,
                         16'(i), 16'(i * 7));
            if (i >= 20) send_request(rrat_pkg::FN_POP_ACK, '0);
        end
        for (int i = 0; i < 12; i++)
            send_request(rrat_pkg::FN_RECV, base + 24'd200 + 24'(i));
        send_request(rrat_pkg::FN_POP_ACK, '0);
        send_request(rrat_pkg::FN_RECV, base + 24'd1);
        for (int i = 0; i < 6; i++) send_request(rrat_pkg::FN_POP_HOLD, '0);
        for (int i = 0; i < 34; i++) send_request(rrat_pkg::FN_POP_ACK, '0);
        drain();
    endtask

    // receiver holds off while requests keep coming
    task automatic test_backpressure();
        long_hold = 1'b1;
        for (int i = 0; i < 12; i++)
            send_request(rrat_pkg::FN_POP_ACK, '0);
        long_hold = 1'b0;
        drain();
    endtask

    task automatic test_random();
        logic [SEQW-1:0] s;
        int pick;
        int n;
        for (int b = 0; b < 20; b++)
        begin
            s = $urandom_range(0, 3) == 0 ? SEQ_MAX - 24'd40 : rseq();
            send_request(rrat_pkg::FN_RECV, s, 1'b1, HW'($urandom()), 16'($urandom()));
            n = $urandom_range(8, 25);
            gaps_on = (b % 4) != 0;
            for (int i = 0; i < n; i++)
            begin
                pick = $urandom_range(0, 19);
                if (pick < 11)
                    send_request(rrat_pkg::FN_RECV, s + 24'($urandom_range(0, 6)) - 24'd1,
                                 1'b0, HW'($urandom()), 16'($urandom()));
                else if (pick < 14)
                    send_request(rrat_pkg::FN_POP_HOLD, rseq());
                else if (pick < 16)
                    send_request(rrat_pkg::FN_POP_ACK, rseq());
                else if (pick < 17)
                    send_request(rrat_pkg::FN_POP_KEEP, rseq());
                else if (pick < 18)
                    send_request(rrat_pkg::FN_RECV, rseq(), 1'($urandom()), HW'($urandom()),
                                 16'($urandom()));
                else
                    send_request(rrat_pkg::FN_RECV, s + 24'($urandom_range(0, 4)), 1'b1);
                if ($urandom_range(0, 2) == 0) s = s + 24'($urandom_range(1, 3));
            end
            if (b == 10) drain();
        end
        gaps_on = 1'b1;
        drain();
    endtask

    // response side: stall pattern plus the long hold-off
    initial
    begin
        int phase;
        int hold_cnt;
        phase = 0;
        hold_cnt = 0;
        rsp.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            phase++;
            if (long_hold && hold_cnt < 300)
            begin
                hold_cnt++;
                rsp.ready <= 1'b0;
            end
            else if ((phase / 64) % 3 == 0)
                rsp.ready <= 1'b1;
            else
                rsp.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge clk)
    begin
        result_t got, want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            got = mk(rsp.ok, rsp.status, rsp.seq_out, rsp.handle_out, rsp.length_out);
            results_seen++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("ERROR: unexpected response %p", got);
            end
            else
            begin
                want = pending_results[0];
                pending_results.delete(0);
                if (want.status == rrat_pkg::ST_DELIVERED && want.ok) delivered_cnt++;
                if (want.status == rrat_pkg::ST_BUFFERED) buffered_cnt++;
                if (want.status == rrat_pkg::ST_ACK_FULL ||
                    want.status == rrat_pkg::ST_HOLD_FULL) full_cnt++;
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: response %0d expected %p got %p",
                                 results_seen, want, got);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        mismatches = 0; results_seen = 0; requests_sent = 0; cycles = 0;
        delivered_cnt = 0; buffered_cnt = 0; full_cnt = 0;
        long_hold = 1'b0; gaps_on = 1'b1;
        seen_any = 1'b0; last_delivered = '0;
        rst_n = 1'b0;
        req.valid = 1'b0; req.func = rrat_pkg::FN_RECV; req.seq_in = '0;
        req.reset_mark = 1'b0; req.payload_handle = '0; req.payload_length = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_full();
        test_backpressure();
        test_random();
        if (pending_results.size() != 0)
        begin
            mismatches++;
            $display("ERROR: %0d responses missing", pending_results.size());
        end
        $display("Sent %0d requests, checked %0d responses: %0d delivered, %0d buffered,",
                 requests_sent, results_seen, delivered_cnt, buffered_cnt);
        $display("  %0d store-full drops, with long response hold-off and idle gaps", full_cnt);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
`default_nettype wire
